[hdl/isq_pkg.sv]
// ----------------------------------------------------------------------------
// isq_pkg
// Shared codes, widths and the cell control bundle of the sequence store.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int OP_W       = 2;
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 7;

    localparam int CAPACITY_DEF   = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // broadcast to every cell on an accepted request
    typedef struct packed {
        logic ins;   // accepted insert or append that succeeds
        logic rem;   // accepted remove that succeeds
        logic rd;    // accepted read that succeeds
        logic acc;   // any accepted request (clears read taps)
    } cell_ctl_t;

endpackage

[hdl/isq_cell.sv]
// ----------------------------------------------------------------------------
// isq_cell
// One storage place of the chain: holds an item, shifts toward either
// neighbor, and drives its read tap when addressed.
// ----------------------------------------------------------------------------
module isq_cell #(
    parameter int IDX     = 0,
    parameter int EXT_W   = 8,
    parameter int ITEM_W  = 32
) (
    input  logic              clk,
    input  isq_pkg::cell_ctl_t ctl,
    input  logic [EXT_W-1:0]  pos,
    input  logic [EXT_W-1:0]  cnt,
    input  logic [ITEM_W-1:0] item_in,
    input  logic [ITEM_W-1:0] left,
    input  logic [ITEM_W-1:0] right,
    output logic [ITEM_W-1:0] entry,
    output logic [ITEM_W-1:0] tap
);
    import isq_pkg::*;

    localparam logic [EXT_W-1:0] IDX_V  = EXT_W'(IDX);
    localparam logic [EXT_W-1:0] IDX1_V = EXT_W'(IDX + 1);

    logic [ITEM_W-1:0] entry_reg;
    logic [ITEM_W-1:0] entry_next;
    logic [ITEM_W-1:0] tap_reg;
    logic [ITEM_W-1:0] tap_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (IDX_V == pos)
            begin
                entry_next = item_in;
            end
            else if ((IDX_V > pos) && (IDX_V <= cnt))
            begin
                entry_next = left;
            end
        end
        else if (ctl.rem)
        begin
            if ((IDX_V >= pos) && (IDX1_V < cnt))
            begin
                entry_next = right;
            end
        end
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.acc)
        begin
            tap_next = (ctl.rd && (IDX_V == pos)) ? entry_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

[hdl/indexed_sequence_store.sv]
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Results are registered: a result is valid in the cycle after its request
// is accepted. Throughput: one request per cycle while in_stall is low;
// every cell shifts in the same cycle. The rate is set by the output
// register, which takes a new result as the previous one is taken.
// Reset: clears the item count and the result valid; stored items are not
// cleared, as only places below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
    parameter int CAPACITY   = isq_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = isq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request side
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [isq_pkg::OP_W-1:0]   op,
    input  logic [isq_pkg::POS_W-1:0]  position,
    input  logic [isq_pkg::DATA_W-1:0] item_in,
    // result side
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [isq_pkg::DATA_W-1:0] item_out,
    output logic [isq_pkg::COUNT_W-1:0] count,
    output logic                       empty_res
);
    import isq_pkg::*;

    // count needs to hold CAPACITY itself; compares run one bit wider than
    // both count and position so nothing wraps
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [EXT_W-1:0] CAP_V = EXT_W'(CAPACITY);

    // --- control state ---
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // --- result payload ---
    logic               ok_reg;
    logic               ok_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               empty_reg;

    logic               accept;
    logic [EXT_W-1:0]   n_x;
    logic [EXT_W-1:0]   pos_x;
    logic [EXT_W-1:0]   pos_eff;
    logic [EXT_W-1:0]   cnt_x_next;
    logic               full;
    cell_ctl_t          ctl;
    logic [ITEM_WIDTH-1:0] item_w;
    logic [ITEM_WIDTH-1:0] entries [CAPACITY];
    logic [ITEM_WIDTH-1:0] taps    [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_bus;

    // A new request is taken whenever the result register is free or being
    // emptied in the same cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign n_x    = EXT_W'(n_reg);
    assign pos_x  = EXT_W'(position);
    assign full   = (n_x == CAP_V);
    assign item_w = ITEM_WIDTH'(item_in);

    // Decode: success of the request and the new count. Append is an insert
    // at the back, so the cells see one shift-in operation for both.
    always_comb
    begin
        ok_next    = 1'b0;
        ctl        = '0;
        pos_eff    = pos_x;
        cnt_x_next = n_x;
        case (op)
            OP_APPEND:
            begin
                pos_eff = n_x;
                ok_next = !full;
            end
            OP_INSERT:
            begin
                ok_next = !full && (pos_x <= n_x);
            end
            OP_REMOVE:
            begin
                ok_next = (pos_x < n_x);
            end
            OP_READ:
            begin
                ok_next = (pos_x < n_x);
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        ctl.acc = accept;
        ctl.ins = accept && ok_next && ((op == OP_APPEND) || (op == OP_INSERT));
        ctl.rem = accept && ok_next && (op == OP_REMOVE);
        ctl.rd  = accept && ok_next && (op == OP_READ);

        if (ctl.ins)
        begin
            cnt_x_next = n_x + EXT_W'(1);
        end
        else if (ctl.rem)
        begin
            cnt_x_next = n_x - EXT_W'(1);
        end
    end

    assign n_next     = cnt_x_next[CNT_W-1:0];
    assign count_next = cnt_x_next[COUNT_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ok_next;
            count_reg <= count_next;
            empty_reg <= (cnt_x_next == '0);
        end
    end

    // Chain of cells: place i takes from place i-1 on insert and from
    // place i+1 on remove; the ends see zero.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_d;
        logic [ITEM_WIDTH-1:0] right_d;

        if (gi == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = entries[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = entries[gi+1];
        end

        isq_cell #(
            .IDX    (gi),
            .EXT_W  (EXT_W),
            .ITEM_W (ITEM_WIDTH)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .pos     (pos_eff),
            .cnt     (n_x),
            .item_in (item_w),
            .left    (left_d),
            .right   (right_d),
            .entry   (entries[gi]),
            .tap     (taps[gi])
        );
    end

    // Read bus: at most one cell holds a nonzero tap, so an OR merges them.
    // Taps are zero for every request except a successful read.
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_bus = rd_bus | taps[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign item_out  = DATA_W'(rd_bus);
    assign count     = count_reg;
    assign empty_res = empty_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EXT_W'(n_reg) <= CAP_V)
        else $error("item count above capacity");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (rd_bus == '0))
        else $error("rejected request returned a nonzero item");

    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (n_reg == '0)))
        else $error("empty flag does not match stored count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_APPEND) && !full) |=> (n_reg == $past(n_reg) + 1'b1))
        else $error("append into non-full store did not grow the count");
`endif

endmodule
